@@ rtl/erfinv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// erfinv_pkg
// Types, widths and constants of the pipelined inverse error function block.
// ----------------------------------------------------------------------------
package erfinv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IFB       = 26;
  localparam int IN_W      = 18;
  localparam int OUT_W     = 20;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DOMAIN = 2'd1,
    ST_INF    = 2'd2
  } status_e;

  typedef struct packed {
    logic    valid;
    logic    neg;
    status_e status;
  } ctrl_t;

  // front end
  localparam int CMP_W = (FRAC_BITS + 2 > IN_W) ? FRAC_BITS + 2 : IN_W;
  localparam int M_W   = 2 * FRAC_BITS + 1;
  localparam int P_W   = $clog2(M_W);
  localparam int E_W   = $clog2(FRAC_BITS + 1);

  // log2 by repeated squaring
  localparam int LOG_STEPS = 30;
  localparam int Y_W       = 31;
  localparam int FR_W      = 30;
  localparam int N_W       = E_W + FR_W;
  localparam int NLO_W     = 17;
  localparam int NHI_W     = N_W - NLO_W;
  localparam int LN_W      = 28;
  localparam int S_W       = N_W + LN_W + 1;
  localparam int NL_W      = 31;

  // closed form
  localparam int CQ_W  = 29;
  localparam int A_W   = 31;
  localparam int AA_W  = 30;
  localparam int SQ_W  = 60;
  localparam int R1    = SQ_W / 2;
  localparam int D_W   = 31;
  localparam int RAD_W = 58;
  localparam int R2    = RAD_W / 2;
  localparam int SHR   = IFB - FRAC_BITS;
  localparam int Q_W   = (SHR > 0) ? R2 + 1 : R2 + 1 - SHR;

  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] THREE_Q60 = 64'd3 << 60;
  localparam logic [63:0] FOUR_Q60  = 64'd4 << 60;
  localparam logic [63:0] C1_NUM    = 64'd3 * (FOUR_Q60 - PI_Q60);
  localparam logic [63:0] C1_DEN    = (64'd4 * (PI_Q60 - THREE_Q60)) >> IFB;
  localparam logic [63:0] C1_Q64    = (C1_NUM + C1_DEN / 64'd2) / C1_DEN;
  localparam logic [63:0] AI_NUM    = (C1_NUM >> 31) * (PI_Q60 >> 31);
  localparam logic [63:0] AI_DEN    = (64'd8 * (PI_Q60 - THREE_Q60)) >> (2 + IFB);
  localparam logic [63:0] AI_Q64    = AI_NUM / AI_DEN;

  localparam logic [CQ_W-1:0] C1_QW   = C1_Q64[CQ_W-1:0];
  localparam logic [CQ_W-1:0] AI_QW   = AI_Q64[CQ_W-1:0];
  localparam logic [LN_W-1:0] LN2_Q28 = 28'hB17217F;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // pipeline stage indexes
  localparam int LG0     = 3;
  localparam int LGN     = LG0 + LOG_STEPS;
  localparam int N_S     = LGN + 1;
  localparam int PR_S    = N_S + 1;
  localparam int NL_S    = PR_S + 1;
  localparam int A_S     = NL_S + 1;
  localparam int SQ_S    = A_S + 1;
  localparam int R1_0    = SQ_S + 1;
  localparam int D_S     = R1_0 + R1 + 1;
  localparam int OUT_S   = D_S + R2 + 1;
  localparam int LATENCY = OUT_S + 1;

endpackage
`default_nettype wire

@@ rtl/inverse_error_function_approx_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_error_function_approx_top
// Pipelined fixed-point inverse error function (closed-form approximation).
// ----------------------------------------------------------------------------
//  channel   | ports                              | handshake
//  ----------+------------------------------------+------------------------------
//  sample    | sample_in_i                        | start_i high, busy_o low
//  result    | erfinv_out_o, status_o             | valid_o strobe, one cycle
//
//  A new sample may enter every cycle while busy_o is low; each result appears after
//  its sample passes the front end registers, 30 squaring steps of the log, two
//  bit-per-stage square roots (30 and 29 stages) and the back end registers.
//  Reset clears only the valid, sign and status flags; busy_o is high in reset.
//  The receiver cannot stall, so the pipeline always advances.
// ----------------------------------------------------------------------------
module inverse_error_function_approx_top (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  output logic                                       busy_o,
  input  wire logic signed [erfinv_pkg::IN_W-1:0]    sample_in_i,
  output logic                                       valid_o,
  output logic signed [erfinv_pkg::OUT_W-1:0]        erfinv_out_o,
  output logic [1:0]                                 status_o
);
  import erfinv_pkg::*;

  localparam logic [CMP_W-1:0] ONE_C  = CMP_W'(1) << FRAC_BITS;
  localparam logic [M_W-1:0]   ONE_SQ = M_W'(1) << (2 * FRAC_BITS);
  localparam logic [P_W-1:0]   TWO_F  = P_W'(2 * FRAC_BITS);

  ctrl_t ctrl_d;
  ctrl_t ctrl_q [0:OUT_S];

  logic             accept;
  logic [IN_W-1:0]  ax_d, ax_q;
  logic [CMP_W-1:0] ax_ext;

  assign busy_o = !rst_ni;
  assign accept = start_i && !busy_o;

  // -------- stage 0: magnitude and special cases
  always_comb begin
    ax_d   = sample_in_i[IN_W-1] ? (~sample_in_i + 1'b1) : sample_in_i;
    ax_ext = CMP_W'(ax_d);
    ctrl_d.valid = accept;
    ctrl_d.neg   = sample_in_i[IN_W-1];
    if (ax_ext > ONE_C) begin
      ctrl_d.status = ST_DOMAIN;
    end else if (ax_ext == ONE_C) begin
      ctrl_d.status = ST_INF;
    end else begin
      ctrl_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= OUT_S; i++) begin
        ctrl_q[i] <= '0;
      end
    end else begin
      ctrl_q[0] <= ctrl_d;
      for (int i = 1; i <= OUT_S; i++) begin
        ctrl_q[i] <= ctrl_q[i-1];
      end
    end
  end

  // -------- stages 1..3: m = 1 - x^2, leading one, normalize
  logic [2*IN_W-1:0]  axsq;
  logic [M_W-1:0]     m_q, m2_q;
  logic [P_W-1:0]     p_d, p_q;
  logic [M_W+FR_W-1:0] ext;

  assign axsq = ax_q * ax_q;

  always_comb begin
    p_d = '0;
    for (int i = 0; i < M_W; i++) begin
      if (m_q[i]) begin
        p_d = P_W'(i);
      end
    end
  end

  assign ext = {m2_q, {FR_W{1'b0}}} >> p_q;

  logic [Y_W-1:0]  lg_y_q [0:LOG_STEPS];
  logic [FR_W-1:0] lg_f_q [0:LOG_STEPS];
  logic [E_W-1:0]  lg_e_q [0:LOG_STEPS];

  always_ff @(posedge clk_i) begin
    ax_q      <= ax_d;
    m_q       <= ONE_SQ - M_W'(axsq);
    m2_q      <= m_q;
    p_q       <= p_d;
    lg_y_q[0] <= ext[Y_W-1:0];
    lg_f_q[0] <= '0;
    lg_e_q[0] <= E_W'(TWO_F - p_q);
  end

  // -------- log2 fraction: one squaring per stage
  for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
    logic [2*Y_W-1:0] sq;
    logic [Y_W:0]     t;
    assign sq = lg_y_q[k] * lg_y_q[k];
    assign t  = sq[2*Y_W-1:FR_W];
    always_ff @(posedge clk_i) begin
      lg_e_q[k+1] <= lg_e_q[k];
      if (t[Y_W]) begin
        lg_y_q[k+1] <= t[Y_W:1];
        lg_f_q[k+1] <= lg_f_q[k] | (FR_W'(1) << (FR_W - 1 - k));
      end else begin
        lg_y_q[k+1] <= t[Y_W-1:0];
        lg_f_q[k+1] <= lg_f_q[k];
      end
    end
  end

  // -------- -ln: n * ln2 in two partial products
  logic [N_W-1:0]         n_q;
  logic [NLO_W+LN_W-1:0]  plo_q;
  logic [NHI_W+LN_W-1:0]  phi_q;
  logic [S_W-1:0]         s_sum;
  logic [NL_W-1:0]        nl_q, nl2_q;
  logic signed [A_W-1:0]  a_d, a_q, a2_q;
  logic [AA_W-1:0]        aa;
  logic [SQ_W-1:0]        aa2_q, nlai_q;

  assign s_sum = (S_W'(phi_q) << NLO_W) + S_W'(plo_q) + (S_W'(1) << 31);
  assign a_d   = $signed({2'b00, C1_QW}) - $signed({1'b0, nl_q[NL_W-1:1]});
  assign aa    = a_q[A_W-1] ? AA_W'(-a_q) : AA_W'(a_q);

  logic [SQ_W-1:0]        rad1_q [0:R1];
  logic [R1+1:0]          rem1_q [0:R1];
  logic [R1-1:0]          root1_q [0:R1];
  logic signed [A_W-1:0]  a1_q [0:R1];

  always_ff @(posedge clk_i) begin
    n_q       <= {lg_e_q[LOG_STEPS], {FR_W{1'b0}}} - N_W'(lg_f_q[LOG_STEPS]);
    plo_q     <= n_q[NLO_W-1:0] * LN2_Q28;
    phi_q     <= n_q[N_W-1:NLO_W] * LN2_Q28;
    nl_q      <= s_sum[32+NL_W-1:32];
    a_q       <= a_d;
    nl2_q     <= nl_q;
    aa2_q     <= SQ_W'(aa * aa);
    nlai_q    <= SQ_W'(nl2_q * AI_QW);
    a2_q      <= a_q;
    rad1_q[0]  <= aa2_q + nlai_q;
    rem1_q[0]  <= '0;
    root1_q[0] <= '0;
    a1_q[0]    <= a2_q;
  end

  // -------- B = isqrt(A^2 + nL/a): one root bit per stage
  for (genvar j = 0; j < R1; j++) begin : g_sq1
    logic [R1+1:0] rt, tr;
    assign rt = {rem1_q[j][R1-1:0], rad1_q[j][SQ_W-1-2*j -: 2]};
    assign tr = {root1_q[j], 2'b01};
    always_ff @(posedge clk_i) begin
      rad1_q[j+1] <= rad1_q[j];
      a1_q[j+1]   <= a1_q[j];
      if (rt >= tr) begin
        rem1_q[j+1]  <= rt - tr;
        root1_q[j+1] <= {root1_q[j][R1-2:0], 1'b1};
      end else begin
        rem1_q[j+1]  <= rt;
        root1_q[j+1] <= {root1_q[j][R1-2:0], 1'b0};
      end
    end
  end

  // -------- R = isqrt((B - A) << IFB)
  logic [D_W-1:0]   diff;
  logic [RAD_W-1:0] rad2_q [0:R2];
  logic [R2+1:0]    rem2_q [0:R2];
  logic [R2-1:0]    root2_q [0:R2];

  assign diff = D_W'($signed({1'b0, root1_q[R1]}) - a1_q[R1]);

  always_ff @(posedge clk_i) begin
    rad2_q[0]  <= RAD_W'({diff, {IFB{1'b0}}});
    rem2_q[0]  <= '0;
    root2_q[0] <= '0;
  end

  for (genvar j = 0; j < R2; j++) begin : g_sq2
    logic [R2+1:0] rt, tr;
    assign rt = {rem2_q[j][R2-1:0], rad2_q[j][RAD_W-1-2*j -: 2]};
    assign tr = {root2_q[j], 2'b01};
    always_ff @(posedge clk_i) begin
      rad2_q[j+1] <= rad2_q[j];
      if (rt >= tr) begin
        rem2_q[j+1]  <= rt - tr;
        root2_q[j+1] <= {root2_q[j][R2-2:0], 1'b1};
      end else begin
        rem2_q[j+1]  <= rt;
        root2_q[j+1] <= {root2_q[j][R2-2:0], 1'b0};
      end
    end
  end

  // -------- output: round to FRAC_BITS, saturate, mirror sign, zero on domain error
  logic [Q_W-1:0]   q_w;
  logic [OUT_W-1:0] mag;
  logic [OUT_W-1:0] out_d, out_q;
  logic [1:0]       status_q;
  ctrl_t            fin;

  if (SHR > 0) begin : g_rnd
    assign q_w = (Q_W'(root2_q[R2]) + (Q_W'(1) << (SHR - 1))) >> SHR;
  end else begin : g_shl
    assign q_w = Q_W'(root2_q[R2]) << (FRAC_BITS - IFB);
  end

  assign fin = ctrl_q[OUT_S-1];
  assign mag = (q_w > Q_W'(OUT_MAX)) ? OUT_MAX : q_w[OUT_W-1:0];

  always_comb begin
    case (fin.status)
      ST_OK:     out_d = fin.neg ? (~mag + 1'b1) : mag;
      ST_INF:    out_d = fin.neg ? OUT_MIN : OUT_MAX;
      default:   out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    status_q <= fin.status;
  end

  assign valid_o      = ctrl_q[OUT_S].valid;
  assign erfinv_out_o = $signed(out_q);
  assign status_o     = status_q;

  // -------- checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY valid_o)
    else $error("result strobe missing after fixed latency");

  a_domain_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == ST_DOMAIN |-> erfinv_out_o == '0)
    else $error("out-of-domain result not zero");

  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != ST_DOMAIN && erfinv_out_o != '0
      |-> erfinv_out_o[OUT_W-1] == $past(sample_in_i[IN_W-1], LATENCY))
    else $error("result sign does not follow sample sign");

endmodule
`default_nettype wire
